@@ sv/ffpra_pkg.sv @@
// Shared types and constants for the first-fit page region allocator.
// No dependencies; used by the top level.
package ffpra_pkg;

    localparam int ADDR_W   = 52;
    localparam int PAGES_W  = 41;
    localparam int STATUS_W = 3;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_OK    = 3'd0;
    localparam t_status ST_NOFIT = 3'd1;
    localparam t_status ST_FULL  = 3'd2;
    localparam t_status ST_SKIP  = 3'd3;
    localparam t_status ST_ZERO  = 3'd4;

    // One region table entry.
    typedef struct packed {
        logic [ADDR_W-1:0]  base;
        logic [PAGES_W-1:0] pages;
        logic               taken;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

@@ sv/ffpra_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffpra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

@@ sv/first_fit_page_region_allocator.sv @@
// First-fit page region allocator, top level.
// Depends on ffpra_pkg and ffpra_ram.
//
// The region table lives in one RAM (base, page count, taken mark per entry) with a
// registered read; only a fill count is kept in flip-flops, so no clearing pass is
// needed after reset. One item is worked at a time. An add transfer or a rejected
// alloc (zero request, empty table) goes from S_IDLE through S_DONE to the output
// register. An alloc walks the table from entry 0 with one read per cycle. Unless the
// table is full, a split then moves every entry above the hit up by one place, one
// read and one write per cycle through the same RAM, and writes the new free entry
// and the trimmed hit entry. The RAM's single write port and single read port set
// these rates. PAGE_BYTES must be a power of two. A finished result sits in the
// output register while the next item is taken in.
module first_fit_page_region_allocator #(
    parameter int MAX_REGIONS = 64,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [51:0] region_base, [103:52] region_length, [104] region_usable,
    // [145:105] request_pages, [151:146] zero
    input  logic [151:0] s_tdata,
    // [0] action: 0 add region, 1 alloc
    input  logic [0:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [2:0] status, [54:3] alloc_address, [55] zero
    output logic [55:0]  m_tdata
);

    localparam int IDX_W      = $clog2(MAX_REGIONS);
    localparam int CNT_W      = $clog2(MAX_REGIONS + 1);
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int ADDR_W     = ffpra_pkg::ADDR_W;
    localparam int PAGES_W    = ffpra_pkg::PAGES_W;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_REGIONS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SCAN   = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_INSERT = 6'b001000,
        S_FINISH = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    // input fields
    logic                in_alloc;
    logic [ADDR_W-1:0]   in_base;
    logic [ADDR_W-1:0]   in_len;
    logic                in_usable;
    logic [PAGES_W-1:0]  in_req;

    assign in_alloc  = s_tuser[0];
    assign in_base   = s_tdata[51:0];
    assign in_len    = s_tdata[103:52];
    assign in_usable = s_tdata[104];
    assign in_req    = s_tdata[145:105];

    // registers
    t_state                r_state,      n_state;
    logic [CNT_W-1:0]      r_count,      n_count;
    logic [CNT_W-1:0]      r_idx,        n_idx;
    logic                  r_pend,       n_pend;
    logic [CNT_W-1:0]      r_pend_idx,   n_pend_idx;
    logic [CNT_W-1:0]      r_hit_idx,    n_hit_idx;
    logic [PAGES_W-1:0]    r_req,        n_req;
    logic [ADDR_W-1:0]     r_hit_base,   n_hit_base;
    logic [PAGES_W-1:0]    r_left,       n_left;
    ffpra_pkg::t_status    r_res_status, n_res_status;
    logic [ADDR_W-1:0]     r_res_addr,   n_res_addr;
    logic                  r_out_valid,  n_out_valid;
    ffpra_pkg::t_status    r_out_status, n_out_status;
    logic [ADDR_W-1:0]     r_out_addr,   n_out_addr;

    // table RAM
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    ffpra_pkg::t_entry     ram_wdata;
    logic [IDX_W-1:0]      ram_raddr;
    ffpra_pkg::t_entry     ram_rdata;

    ffpra_ram #(
        .WIDTH (ffpra_pkg::ENTRY_W),
        .DEPTH (MAX_REGIONS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // add path: whole pages in the region, first page kept as header
    logic [ADDR_W-1:0]  add_pages_full;
    logic [ADDR_W-1:0]  add_pages_m1;
    logic [PAGES_W-1:0] add_pages;
    logic               add_len_ok;
    logic [ADDR_W-1:0]  add_base;

    assign add_pages_full = in_len >> PAGE_SHIFT;
    assign add_len_ok     = add_pages_full >= ADDR_W'(2);
    assign add_pages_m1   = add_pages_full - ADDR_W'(1);
    // saturate to the page count width
    assign add_pages      = (|add_pages_m1[ADDR_W-1:PAGES_W]) ? '1
                                                              : add_pages_m1[PAGES_W-1:0];
    assign add_base       = in_base + ADDR_W'(PAGE_BYTES);

    // split entry starts one header page past the granted pages (wraps mod 2^52)
    logic [ADDR_W-1:0]  split_base;
    assign split_base = r_hit_base + ((ADDR_W'(r_req) + ADDR_W'(1)) << PAGE_SHIFT);

    logic               shift_issue;
    logic [CNT_W-1:0]   shift_dst;
    logic [CNT_W-1:0]   ins_idx;
    logic               scan_hit;

    assign shift_issue = r_idx > r_hit_idx;
    assign shift_dst   = r_pend_idx + CNT_W'(1);
    assign ins_idx     = r_hit_idx + CNT_W'(1);
    assign scan_hit    = r_pend && !ram_rdata.taken && (ram_rdata.pages >= r_req);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_hit_idx    = r_hit_idx;
        n_req        = r_req;
        n_hit_base   = r_hit_base;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;

        ram_we    = 1'b0;
        ram_waddr = r_count[IDX_W-1:0];
        ram_wdata = '0;
        ram_raddr = r_idx[IDX_W-1:0];

        s_tready  = (r_state == S_IDLE);

        // output register drains on its own
        if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_res_addr = '0;
                    if (!in_alloc) begin
                        if (!in_usable || !add_len_ok) begin
                            n_res_status = ffpra_pkg::ST_SKIP;
                        end else if (r_count == CNT_MAX) begin
                            n_res_status = ffpra_pkg::ST_FULL;
                        end else begin
                            ram_we          = 1'b1;
                            ram_waddr       = r_count[IDX_W-1:0];
                            ram_wdata.base  = add_base;
                            ram_wdata.pages = add_pages;
                            ram_wdata.taken = 1'b0;
                            n_count         = r_count + CNT_W'(1);
                            n_res_status    = ffpra_pkg::ST_OK;
                        end
                        n_state = S_DONE;
                    end else if (in_req == '0) begin
                        n_res_status = ffpra_pkg::ST_ZERO;
                        n_state      = S_DONE;
                    end else if (r_count == '0) begin
                        n_res_status = ffpra_pkg::ST_NOFIT;
                        n_state      = S_DONE;
                    end else begin
                        n_req   = in_req;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end

            // one read issued per cycle; data for the previous index checked here
            S_SCAN: begin
                if (scan_hit) begin
                    n_pend     = 1'b0;
                    n_hit_idx  = r_pend_idx;
                    n_hit_base = ram_rdata.base;
                    n_left     = ram_rdata.pages - r_req;
                    if (ram_rdata.pages == r_req) begin
                        // exact fit: mark taken in place
                        ram_we          = 1'b1;
                        ram_waddr       = r_pend_idx[IDX_W-1:0];
                        ram_wdata       = ram_rdata;
                        ram_wdata.taken = 1'b1;
                        n_res_status    = ffpra_pkg::ST_OK;
                        n_res_addr      = ram_rdata.base;
                        n_state         = S_DONE;
                    end else if (r_count == CNT_MAX) begin
                        n_res_status = ffpra_pkg::ST_FULL;
                        n_state      = S_DONE;
                    end else begin
                        n_idx   = r_count - CNT_W'(1);
                        n_state = S_SHIFT;
                    end
                end else if (r_pend && (r_pend_idx == r_count - CNT_W'(1))) begin
                    n_pend       = 1'b0;
                    n_res_status = ffpra_pkg::ST_NOFIT;
                    n_state      = S_DONE;
                end else begin
                    n_pend     = r_idx < r_count;
                    n_pend_idx = r_idx;
                    if (r_idx < r_count) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end
            end

            // move entries above the hit up one place, top down
            S_SHIFT: begin
                if (r_pend) begin
                    ram_we    = 1'b1;
                    ram_waddr = shift_dst[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end
                n_pend     = shift_issue;
                n_pend_idx = r_idx;
                if (shift_issue) begin
                    n_idx = r_idx - CNT_W'(1);
                end
                if (!shift_issue && !r_pend) begin
                    n_state = S_INSERT;
                end
            end

            S_INSERT: begin
                ram_we          = 1'b1;
                ram_waddr       = ins_idx[IDX_W-1:0];
                ram_wdata.base  = split_base;
                ram_wdata.pages = r_left - PAGES_W'(1);
                ram_wdata.taken = 1'b0;
                n_count         = r_count + CNT_W'(1);
                n_state         = S_FINISH;
            end

            S_FINISH: begin
                ram_we          = 1'b1;
                ram_waddr       = r_hit_idx[IDX_W-1:0];
                ram_wdata.base  = r_hit_base;
                ram_wdata.pages = r_req;
                ram_wdata.taken = 1'b1;
                n_res_status    = ffpra_pkg::ST_OK;
                n_res_addr      = r_hit_base;
                n_state         = S_DONE;
            end

            // hand the result to the output register once it is free
            S_DONE: begin
                if (!r_out_valid || m_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_addr   = r_res_addr;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_pend_idx   <= n_pend_idx;
        r_hit_idx    <= n_hit_idx;
        r_req        <= n_req;
        r_hit_base   <= n_hit_base;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {1'b0, r_out_addr, r_out_status};

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("region count above table size");

    a_err_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ffpra_pkg::ST_OK)) |-> (r_out_addr == '0))
        else $error("nonzero address on failed transfer");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && !s_tuser[0] && (n_res_status == ffpra_pkg::ST_OK))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("accepted add did not grow the table");

    a_shift_above_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SHIFT) && r_pend) |-> (r_pend_idx > r_hit_idx))
        else $error("shift moved an entry at or below the hit");
`endif

endmodule
